// ===== rtl/tensor_slice_index_map_macros.svh =====
// Assertion helpers shared by several of the RTL files.
`ifndef TENSOR_SLICE_INDEX_MAP_MACROS_SVH
`define TENSOR_SLICE_INDEX_MAP_MACROS_SVH

// Same-cycle implication.
`define TSIM_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tsim check failed");

// Next-cycle implication.
`define TSIM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tsim check failed");

// Implication after a fixed number of cycles.
`define TSIM_ASSERT_DELAY(label, clk, rst, pre, n, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##n (post)) \
      else $error("tsim check failed");

`endif

// ===== rtl/tsim_pkg.sv =====
`timescale 1ns / 1ps
package tsim_pkg;

   localparam int MAX_RANK       = 4;
   localparam int INDEX_BITS     = 24;
   localparam int NUM_DIMS       = 4;
   localparam int DIM_BITS       = 12;
   localparam int RANK_BITS      = 3;
   localparam int AXIS_BITS      = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;
   localparam int PROD_BITS      = NUM_DIMS * DIM_BITS;
   localparam int SETTLE_CYCLES  = 4;
   localparam int SETTLE_BITS    = 3;
   // input register, two dividers, four tail stages
   localparam int PIPE_LATENCY   = 2 * INDEX_BITS + 5;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_RANGE  = 2'd1,
      STATUS_CONFIG = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_RANK   = 3'd0,
      REG_DIM_0  = 3'd1,
      REG_DIM_1  = 3'd2,
      REG_DIM_2  = 3'd3,
      REG_DIM_3  = 3'd4,
      REG_AXIS   = 3'd5,
      REG_START  = 3'd6,
      REG_LENGTH = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [INDEX_BITS:0]   block;
      logic [INDEX_BITS:0]   dest_len;
      logic [DIM_BITS-1:0]   axis_size;
      logic [DIM_BITS-1:0]   start;
      logic [DIM_BITS-1:0]   length;
      logic                  valid;
   } cfg_type;

   typedef struct packed {
      status_type            status;
      logic [INDEX_BITS-1:0] offset;
   } side_type;

endpackage

// ===== rtl/tsim_cfg.sv =====
`timescale 1ns / 1ps
`include "tensor_slice_index_map_macros.svh"
module tsim_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsim_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tsim_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output tsim_pkg::cfg_type                   cfg,
   output logic                                busy
);
   import tsim_pkg::*;

   logic [RANK_BITS-1:0]   rank_ff;
   logic [DIM_BITS-1:0]    dim_ff [NUM_DIMS];
   logic [AXIS_BITS-1:0]   axis_ff;
   logic [DIM_BITS-1:0]    start_ff;
   logic [DIM_BITS-1:0]    length_ff;
   logic [SETTLE_BITS-1:0] settle_ff;
   logic                   csr_write;

   logic [DIM_BITS-1:0]    tot_d [NUM_DIMS];
   logic [DIM_BITS-1:0]    out_d [NUM_DIMS];
   logic [DIM_BITS-1:0]    blk_d [NUM_DIMS];
   logic                   zero_dim;
   logic                   bad_in;
   logic [DIM_BITS-1:0]    axis_size;

   logic [2*DIM_BITS-1:0]  tot01_ff, tot23_ff, out01_ff, out23_ff, blk01_ff, blk23_ff;
   logic                   bad1_ff;
   logic [PROD_BITS-1:0]   total_ff, outer_ff, blk2_ff;
   logic                   bad2_ff;
   logic [2*INDEX_BITS+1:0] ob_full;
   logic [INDEX_BITS:0]    ob_ff, blk3_ff;
   logic                   valid3_ff;
   logic [INDEX_BITS+DIM_BITS:0] dl_full;
   logic [INDEX_BITS:0]    dest_len_ff, block_ff;
   logic                   valid_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff   <= RANK_BITS'(1);
         for (int k = 0; k < NUM_DIMS; k++) dim_ff[k] <= DIM_BITS'(1);
         axis_ff   <= '0;
         start_ff  <= '0;
         length_ff <= DIM_BITS'(1);
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_RANK:   rank_ff   <= csr_data[RANK_BITS-1:0];
            REG_DIM_0:  dim_ff[0] <= csr_data[DIM_BITS-1:0];
            REG_DIM_1:  dim_ff[1] <= csr_data[DIM_BITS-1:0];
            REG_DIM_2:  dim_ff[2] <= csr_data[DIM_BITS-1:0];
            REG_DIM_3:  dim_ff[3] <= csr_data[DIM_BITS-1:0];
            REG_AXIS:   axis_ff   <= csr_data[AXIS_BITS-1:0];
            REG_START:  start_ff  <= csr_data[DIM_BITS-1:0];
            REG_LENGTH: length_ff <= csr_data[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // hold off new items until the derived values have settled
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         settle_ff <= SETTLE_BITS'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - SETTLE_BITS'(1);
      end
   end
   assign busy = (settle_ff != '0);

   // per-dimension factors for total, outer and inner products
   assign axis_size = dim_ff[axis_ff];
   always_comb begin
      zero_dim = 1'b0;
      for (int k = 0; k < NUM_DIMS; k++) begin
         tot_d[k] = (k < int'(rank_ff)) ? dim_ff[k] : DIM_BITS'(1);
         out_d[k] = (k < int'(rank_ff) && k < int'(axis_ff)) ? dim_ff[k] : DIM_BITS'(1);
         blk_d[k] = (k < int'(rank_ff) && k > int'(axis_ff)) ? dim_ff[k] : DIM_BITS'(1);
         if (k < int'(rank_ff) && dim_ff[k] == '0) zero_dim = 1'b1;
      end
      bad_in = (rank_ff == '0) || (int'(rank_ff) > MAX_RANK) || (int'(rank_ff) > NUM_DIMS)
            || (RANK_BITS'(axis_ff) >= rank_ff) || (length_ff == '0) || zero_dim
            || ((DIM_BITS+1)'(start_ff) + (DIM_BITS+1)'(length_ff)
                > (DIM_BITS+1)'(axis_size));
   end

   always_ff @(posedge clock) begin
      tot01_ff <= tot_d[0] * tot_d[1];
      tot23_ff <= tot_d[2] * tot_d[3];
      out01_ff <= out_d[0] * out_d[1];
      out23_ff <= out_d[2] * out_d[3];
      blk01_ff <= blk_d[0] * blk_d[1];
      blk23_ff <= blk_d[2] * blk_d[3];
      bad1_ff  <= bad_in;
   end

   always_ff @(posedge clock) begin
      total_ff <= tot01_ff * tot23_ff;
      outer_ff <= out01_ff * out23_ff;
      blk2_ff  <= blk01_ff * blk23_ff;
      bad2_ff  <= bad1_ff;
   end

   assign ob_full = outer_ff[INDEX_BITS:0] * blk2_ff[INDEX_BITS:0];
   always_ff @(posedge clock) begin
      valid3_ff <= !bad2_ff && (total_ff <= (PROD_BITS'(1) << INDEX_BITS));
      ob_ff     <= ob_full[INDEX_BITS:0];
      blk3_ff   <= blk2_ff[INDEX_BITS:0];
   end

   assign dl_full = ob_ff * length_ff;
   always_ff @(posedge clock) begin
      valid_ff    <= valid3_ff;
      dest_len_ff <= dl_full[INDEX_BITS:0];
      block_ff    <= blk3_ff;
   end

   assign cfg.block     = block_ff;
   assign cfg.dest_len  = dest_len_ff;
   assign cfg.axis_size = axis_size;
   assign cfg.start     = start_ff;
   assign cfg.length    = length_ff;
   assign cfg.valid     = valid_ff;

   `TSIM_ASSERT_NEXT(a_write_busy, clock, reset, csr_write, busy)

endmodule

// ===== rtl/tsim_div.sv =====
`timescale 1ns / 1ps
`include "tensor_slice_index_map_macros.svh"
module tsim_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [tsim_pkg::INDEX_BITS-1:0]   dividend,
   input  logic [tsim_pkg::INDEX_BITS:0]     divisor,
   input  tsim_pkg::side_type                in_side,
   output logic                              out_valid,
   output logic [tsim_pkg::INDEX_BITS-1:0]   quotient,
   output logic [tsim_pkg::INDEX_BITS-1:0]   remainder,
   output tsim_pkg::side_type                out_side
);
   import tsim_pkg::*;

   localparam int IB = INDEX_BITS;

   logic          vld_ff  [IB];
   logic [IB-1:0] dvd_ff  [IB];
   logic [IB-1:0] quo_ff  [IB];
   logic [IB-1:0] rem_ff  [IB];
   side_type      side_ff [IB];

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < IB; k++) begin : g_stage
      logic          vld_prev;
      logic [IB-1:0] dvd_prev;
      logic [IB-1:0] quo_prev;
      logic [IB-1:0] rem_prev;
      side_type      side_prev;
      logic [IB:0]   trial;
      logic [IB:0]   diff;
      logic          fit;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign dvd_prev  = dividend;
         assign quo_prev  = '0;
         assign rem_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_rest
         assign vld_prev  = vld_ff[k-1];
         assign dvd_prev  = dvd_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign trial = {rem_prev, dvd_prev[IB-1-k]};
      assign fit   = (trial >= divisor);
      assign diff  = trial - divisor;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         dvd_ff[k]  <= dvd_prev;
         quo_ff[k]  <= {quo_prev[IB-2:0], fit};
         rem_ff[k]  <= fit ? diff[IB-1:0] : trial[IB-1:0];
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = vld_ff[IB-1];
   assign quotient  = quo_ff[IB-1];
   assign remainder = rem_ff[IB-1];
   assign out_side  = side_ff[IB-1];

   `TSIM_ASSERT_IMPLIES(a_rem_below_div, clock, reset,
      out_valid && divisor != '0, (IB+1)'(remainder) < divisor)
   `TSIM_ASSERT_DELAY(a_div_latency, clock, reset, in_valid, IB, out_valid)

endmodule

// ===== rtl/tsim_tail.sv =====
`timescale 1ns / 1ps
module tsim_tail (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [tsim_pkg::INDEX_BITS-1:0]   quotient,
   input  logic [tsim_pkg::INDEX_BITS-1:0]   remainder,
   input  tsim_pkg::side_type                in_side,
   input  tsim_pkg::cfg_type                 cfg,
   output logic                              out_valid,
   output logic [tsim_pkg::INDEX_BITS-1:0]   source_index,
   output tsim_pkg::status_type              status
);
   import tsim_pkg::*;

   localparam int IB = INDEX_BITS;

   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IB+DIM_BITS-1:0] prod1_ff;
   logic [IB-1:0]          rem1_ff;
   side_type               side1_ff, side2_ff, side3_ff;
   logic [IB+DIM_BITS:0]   sb_sum;
   logic [IB-1:0]          sb_ff;
   logic [2*IB:0]          prod2_full;
   logic [IB-1:0]          prod2_ff;
   logic [IB-1:0]          sum_in;
   logic [IB-1:0]          index_ff;
   status_type             status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // scale the outer block count by the full axis size
   always_ff @(posedge clock) begin
      prod1_ff <= quotient * cfg.axis_size;
      rem1_ff  <= remainder;
      side1_ff <= in_side;
   end

   // add the position inside the slice and the slice start
   assign sb_sum = (IB+DIM_BITS+1)'(prod1_ff) + (IB+DIM_BITS+1)'(rem1_ff)
                 + (IB+DIM_BITS+1)'(cfg.start);
   always_ff @(posedge clock) begin
      sb_ff    <= sb_sum[IB-1:0];
      side2_ff <= side1_ff;
   end

   // back to elements; only the low index bits survive
   assign prod2_full = sb_ff * cfg.block;
   always_ff @(posedge clock) begin
      prod2_ff <= prod2_full[IB-1:0];
      side3_ff <= side2_ff;
   end

   assign sum_in = prod2_ff + side3_ff.offset;
   always_ff @(posedge clock) begin
      index_ff  <= (side3_ff.status == STATUS_OK) ? sum_in : '0;
      status_ff <= side3_ff.status;
   end

   assign out_valid    = v4_ff;
   assign source_index = index_ff;
   assign status       = status_ff;

endmodule

// ===== rtl/tensor_slice_index_map.sv =====
`timescale 1ns / 1ps
`include "tensor_slice_index_map_macros.svh"
// Channel   Direction  Transfer when             Ports
// request   in         start && !busy           req_dest_index
// response  out        rsp_valid (one cycle)    rsp_source_index, rsp_status
// csr       in         csr_valid && csr_ready   csr_index, csr_data
//
// One request per cycle while busy is low; each response passes through an input register,
// two pipelined restoring dividers of one quotient bit per stage and four multiply-add stages.
// Synchronous reset clears the registers to their defaults and keeps busy high while the
// derived block size, destination length and validity settle.
// Every csr write raises busy in the same way; csr_ready is always high.
// The response side has no back pressure: each result shows for exactly one cycle.
module tensor_slice_index_map (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tsim_pkg::INDEX_BITS-1:0]     req_dest_index,
   output logic                                rsp_valid,
   output logic [tsim_pkg::INDEX_BITS-1:0]     rsp_source_index,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsim_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tsim_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import tsim_pkg::*;

   cfg_type               cfg;
   logic                  accept;

   // input stage: range and config check
   logic                  s0_vld_ff;
   logic [INDEX_BITS-1:0] s0_index_ff;
   status_type            s0_status_ff;
   status_type            status_in;
   side_type              s0_side;

   // first divider: element index over inner block size
   logic                  d1_vld;
   logic [INDEX_BITS-1:0] d1_quo, d1_rem;
   side_type              d1_side;
   side_type              d2_side_in;

   // second divider: block number over slice length
   logic                  d2_vld;
   logic [INDEX_BITS-1:0] d2_quo, d2_rem;
   side_type              d2_side;
   status_type            rsp_status_t;

   tsim_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .busy      (busy)
   );

   assign accept = start && !busy;

   // config errors take priority over an index past the slice end
   always_comb begin
      if (!cfg.valid) begin
         status_in = STATUS_CONFIG;
      end else if ((INDEX_BITS+1)'(req_dest_index) >= cfg.dest_len) begin
         status_in = STATUS_RANGE;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s0_index_ff  <= req_dest_index;
      s0_status_ff <= status_in;
   end

   assign s0_side.status = s0_status_ff;
   assign s0_side.offset = '0;

   tsim_div u_div_block (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_vld_ff),
      .dividend  (s0_index_ff),
      .divisor   (cfg.block),
      .in_side   (s0_side),
      .out_valid (d1_vld),
      .quotient  (d1_quo),
      .remainder (d1_rem),
      .out_side  (d1_side)
   );

   // carry the offset inside the block to the final add
   assign d2_side_in.status = d1_side.status;
   assign d2_side_in.offset = d1_rem;

   tsim_div u_div_slice (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_vld),
      .dividend  (d1_quo),
      .divisor   ((INDEX_BITS+1)'(cfg.length)),
      .in_side   (d2_side_in),
      .out_valid (d2_vld),
      .quotient  (d2_quo),
      .remainder (d2_rem),
      .out_side  (d2_side)
   );

   tsim_tail u_tail (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (d2_vld),
      .quotient     (d2_quo),
      .remainder    (d2_rem),
      .in_side      (d2_side),
      .cfg          (cfg),
      .out_valid    (rsp_valid),
      .source_index (rsp_source_index),
      .status       (rsp_status_t)
   );

   assign rsp_status = rsp_status_t;

   `TSIM_ASSERT_DELAY(a_pipe_latency, clock, reset, accept, PIPE_LATENCY, rsp_valid)
   `TSIM_ASSERT_IMPLIES(a_error_zero, clock, reset,
      rsp_valid && rsp_status_t != STATUS_OK, rsp_source_index == '0)

endmodule
